// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the time arithmetic pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define SNSA_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("time arithmetic assertion failed");

// Next-cycle implication, quiet while reset is high.
`define SNSA_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("time arithmetic assertion failed");

`endif

// ----- rtl/snsa_pkg.sv -----
`default_nettype none

package snsa_pkg;

  // Default width of the seconds part
  localparam int unsigned SEC_BITS_DEF = 32;

  // Field widths of the stream ports
  localparam int unsigned SEC_W  = 32;
  localparam int unsigned NSEC_W = 30;
  localparam int unsigned SCL_W  = 32;
  localparam int unsigned FUNC_W = 3;

  // Nanoseconds in one second and the largest normalised nanosecond value
  localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [NSEC_W-1:0] NS_TOP     = 30'd999999999;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_MIN = 3'd4,
    FN_MAX = 3'd5
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_OVF  = 2'd2,
    ST_DIV0 = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/snsa_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per register stage.
// The starting remainder must be below the divisor for an exact result.
module snsa_div #(
  parameter int unsigned QW     = 32,
  parameter int unsigned DW     = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DW-1:0]     in_rem,
  input  wire logic [QW-1:0]     in_bits,
  input  wire logic [DW-1:0]     in_divisor,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [QW-1:0]          out_quot,
  output logic [DW-1:0]          out_rem,
  output logic [SIDE_W-1:0]      out_side
);

  logic              v    [0:QW];
  logic [DW-1:0]     rem  [0:QW];
  logic [QW-1:0]     x    [0:QW];
  logic [DW-1:0]     dv   [0:QW];
  logic [SIDE_W-1:0] side [0:QW];

  assign v[0]    = in_valid;
  assign rem[0]  = in_rem;
  assign x[0]    = in_bits;
  assign dv[0]   = in_divisor;
  assign side[0] = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        ge;

    // Bring down the next dividend bit and try the subtraction
    assign rem_sh = {rem[k], x[k][QW-1]};
    assign diff   = rem_sh - {1'b0, dv[k]};
    assign ge     = rem_sh >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    // Shift the quotient bit in where the dividend bit left
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        x[k+1]    <= {x[k][QW-2:0], ge};
        dv[k+1]   <= dv[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = v[QW];
  assign out_quot  = x[QW];
  assign out_rem   = rem[QW];
  assign out_side  = side[QW];

endmodule

`default_nettype wire

// ----- rtl/snsa_result.sv -----
`default_nettype none

// Final stage: pick the result by operation, saturate and register it.
module snsa_result #(
  parameter int unsigned SEC_BITS = snsa_pkg::SEC_BITS_DEF,
  parameter int unsigned SW       = SEC_BITS + 1,
  parameter int unsigned PB_W     = SW + 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [snsa_pkg::FUNC_W-1:0]       func,
  input  wire logic [SW-1:0]                     ls,
  input  wire logic [snsa_pkg::NSEC_W-1:0]       ln,
  input  wire logic [SW-1:0]                     rs,
  input  wire logic [snsa_pkg::NSEC_W-1:0]       rn,
  input  wire logic [snsa_pkg::SCL_W-1:0]        scale,
  input  wire logic                              gt,
  input  wire logic                              eq,
  input  wire logic [PB_W-1:0]                   prod_b,
  input  wire logic [SW-1:0]                     quot_a,
  input  wire logic [31:0]                       quot,
  input  wire logic [31:0]                       rem,
  output logic                                   out_valid,
  output logic [snsa_pkg::SEC_W-1:0]             res_sec,
  output logic [snsa_pkg::NSEC_W-1:0]            res_nsec,
  output logic                                   res_gt,
  output logic                                   res_eq,
  output snsa_pkg::status_t                      res_status
);

  localparam int unsigned PW = PB_W + 1;
  localparam logic [PW-1:0] SEC_MAX = (PW'(1) << SEC_BITS) - PW'(1);

  logic [PW-1:0]                 s;
  logic [snsa_pkg::NSEC_W-1:0]   n;
  snsa_pkg::status_t             st;
  logic [snsa_pkg::NSEC_W:0]     ns_sum;
  logic [snsa_pkg::NSEC_W:0]     ns_diff;
  logic [snsa_pkg::SEC_W-1:0]    sec_next;
  logic [snsa_pkg::NSEC_W-1:0]   nsec_next;
  snsa_pkg::status_t             status_next;

  assign ns_sum  = {1'b0, ln} + {1'b0, rn};
  assign ns_diff = {1'b0, ln} + {1'b0, snsa_pkg::NS_PER_SEC} - {1'b0, rn};

  // Operation select
  always_comb begin
    s  = '0;
    n  = '0;
    st = snsa_pkg::ST_OK;
    case (snsa_pkg::func_t'(func))
      snsa_pkg::FN_ADD: begin
        if (ns_sum >= {1'b0, snsa_pkg::NS_PER_SEC}) begin
          s = PW'(ls) + PW'(rs) + PW'(1);
          n = snsa_pkg::NSEC_W'(ns_sum - {1'b0, snsa_pkg::NS_PER_SEC});
        end else begin
          s = PW'(ls) + PW'(rs);
          n = ns_sum[snsa_pkg::NSEC_W-1:0];
        end
      end
      snsa_pkg::FN_SUB: begin
        if (!gt && !eq) begin
          st = snsa_pkg::ST_NEG;
        end else if (ln < rn) begin
          s = PW'(ls) - PW'(rs) - PW'(1);
          n = ns_diff[snsa_pkg::NSEC_W-1:0];
        end else begin
          s = PW'(ls) - PW'(rs);
          n = ln - rn;
        end
      end
      snsa_pkg::FN_MUL: begin
        s = PW'(prod_b) + PW'(quot);
        n = rem[snsa_pkg::NSEC_W-1:0];
      end
      snsa_pkg::FN_DIV: begin
        if (scale == '0) begin
          st = snsa_pkg::ST_DIV0;
        end else begin
          s = PW'(quot_a);
          n = quot[snsa_pkg::NSEC_W-1:0];
        end
      end
      snsa_pkg::FN_MIN: begin
        s = gt ? PW'(rs) : PW'(ls);
        n = gt ? rn : ln;
      end
      snsa_pkg::FN_MAX: begin
        s = gt ? PW'(ls) : PW'(rs);
        n = gt ? ln : rn;
      end
      default: begin
        s  = '0;
        n  = '0;
        st = snsa_pkg::ST_OK;
      end
    endcase
  end

  // Saturate on seconds overflow, clear on errors
  always_comb begin
    status_next = st;
    if (st == snsa_pkg::ST_OK && s > SEC_MAX) begin
      status_next = snsa_pkg::ST_OVF;
    end
    if (status_next == snsa_pkg::ST_OVF) begin
      sec_next  = SEC_MAX[snsa_pkg::SEC_W-1:0];
      nsec_next = snsa_pkg::NS_TOP;
    end else if (status_next != snsa_pkg::ST_OK) begin
      sec_next  = '0;
      nsec_next = '0;
    end else begin
      sec_next  = s[snsa_pkg::SEC_W-1:0];
      nsec_next = n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Output register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (en) begin
      res_sec    <= sec_next;
      res_nsec   <= nsec_next;
      res_gt     <= gt;
      res_eq     <= eq;
      res_status <= status_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/seconds_nanoseconds_alu_core.sv -----
// Channel  Direction  Payload (lowest bits first)
// s_*      in         tuser: func; tdata: lhs_sec, lhs_ns, rhs_sec, rhs_ns, scale
// m_*      out        tdata: res_sec, res_nsec, lhs_greater, lhs_equal, status
//
// One transaction per cycle sustained while m_tready does not stall the output.
// The pipeline holds two restoring dividers of one bit per stage: one of
// SEC_BITS + 1 stages for the seconds, one of 32 stages for nanoseconds.
// Synchronous active-high reset clears every valid bit.
// A stall at the output freezes the whole pipeline; s_tready follows it.
`default_nettype none

module seconds_nanoseconds_alu_core #(
  parameter int unsigned SEC_BITS = snsa_pkg::SEC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [159:0] s_tdata,  // lhs_sec, lhs_ns, rhs_sec, rhs_ns, scale, pad
  input  wire logic [2:0]   s_tuser,  // func
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata   // res_sec, res_nsec, lhs_greater, lhs_equal, status, pad
);

`include "assert_macros.svh"

  localparam int unsigned SW   = SEC_BITS + 1;
  localparam int unsigned PB_W = SW + 32;
  localparam int unsigned IN_W = (SEC_BITS < 32) ? SEC_BITS : 32;
  localparam int unsigned NW   = snsa_pkg::NSEC_W;

  typedef struct packed {
    logic [2:0]      func;
    logic [SW-1:0]   ls;
    logic [NW-1:0]   ln;
    logic [SW-1:0]   rs;
    logic [NW-1:0]   rn;
    logic [31:0]     scale;
    logic            gt;
    logic            eq;
    logic [61:0]     prod_a;
    logic [PB_W-1:0] prod_b;
  } c_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [SW-1:0]   ls;
    logic [NW-1:0]   ln;
    logic [SW-1:0]   rs;
    logic [NW-1:0]   rn;
    logic [31:0]     scale;
    logic            gt;
    logic            eq;
    logic [PB_W-1:0] prod_b;
    logic [SW-1:0]   a;
  } f_t;

  logic en;

  // Stage A: input register
  logic          a_v;
  logic [2:0]    a_func;
  logic [31:0]   a_lsec, a_rsec, a_scale;
  logic [NW-1:0] a_lnsec, a_rnsec;

  // Stage B: normalised operands
  logic          b_v;
  logic [2:0]    b_func;
  logic [SW-1:0] b_ls, b_rs;
  logic [NW-1:0] b_ln, b_rn;
  logic [31:0]   b_scale;
  logic          l_ge, r_ge;

  // Stage C: compare and products
  logic c_v;
  c_t   c_q;

  // Seconds divider
  logic          d1_v;
  logic [SW-1:0] d1_a;
  logic [31:0]   d1_r;
  c_t            d1_side;

  // Stage E: remainder scaled to nanoseconds
  logic          e_v;
  c_t            e_c;
  logic [SW-1:0] e_a;
  logic [61:0]   e_rprod;

  // Stage F: dividend and divisor for the nanosecond divider
  logic        f_v;
  f_t          f_q;
  logic [61:0] f_dvd;
  logic [31:0] f_dvs;

  // Nanosecond divider
  logic        d2_v;
  logic [31:0] d2_q, d2_r;
  f_t          d2_side;

  // Result
  logic                       r_v;
  logic [31:0]                r_sec;
  logic [NW-1:0]              r_nsec;
  logic                       r_gt, r_eq;
  snsa_pkg::status_t          r_status;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
      b_v <= a_v;
      c_v <= b_v;
      e_v <= d1_v;
      f_v <= e_v;
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (en) begin
      a_func  <= s_tuser;
      a_lsec  <= s_tdata[31:0];
      a_lnsec <= s_tdata[61:32];
      a_rsec  <= s_tdata[93:62];
      a_rnsec <= s_tdata[123:94];
      a_scale <= s_tdata[155:124];
    end
  end

  // Fold whole seconds out of the nanoseconds
  assign l_ge = a_lnsec >= snsa_pkg::NS_PER_SEC;
  assign r_ge = a_rnsec >= snsa_pkg::NS_PER_SEC;

  always_ff @(posedge clk) begin
    if (en) begin
      b_func  <= a_func;
      b_ls    <= SW'(a_lsec[IN_W-1:0]) + SW'(l_ge);
      b_rs    <= SW'(a_rsec[IN_W-1:0]) + SW'(r_ge);
      b_ln    <= l_ge ? a_lnsec - snsa_pkg::NS_PER_SEC : a_lnsec;
      b_rn    <= r_ge ? a_rnsec - snsa_pkg::NS_PER_SEC : a_rnsec;
      b_scale <= a_scale;
    end
  end

  // Compare the operands, form the scale products
  always_ff @(posedge clk) begin
    if (en) begin
      c_q.func   <= b_func;
      c_q.ls     <= b_ls;
      c_q.ln     <= b_ln;
      c_q.rs     <= b_rs;
      c_q.rn     <= b_rn;
      c_q.scale  <= b_scale;
      c_q.gt     <= (b_ls > b_rs) || ((b_ls == b_rs) && (b_ln > b_rn));
      c_q.eq     <= (b_ls == b_rs) && (b_ln == b_rn);
      c_q.prod_a <= 62'(b_scale) * 62'(b_rn);
      c_q.prod_b <= PB_W'(b_scale) * PB_W'(b_rs);
    end
  end

  // Whole seconds of the quotient: lhs seconds over scale
  snsa_div #(
    .QW     (SW),
    .DW     (32),
    .SIDE_W ($bits(c_t))
  ) u_div_sec (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (c_v),
    .in_rem     ('0),
    .in_bits    (c_q.ls),
    .in_divisor (c_q.scale),
    .in_side    (c_q),
    .out_valid  (d1_v),
    .out_quot   (d1_a),
    .out_rem    (d1_r),
    .out_side   (d1_side)
  );

  // Scale the seconds remainder to nanoseconds
  always_ff @(posedge clk) begin
    if (en) begin
      e_c     <= d1_side;
      e_a     <= d1_a;
      e_rprod <= 62'(d1_r) * 62'(snsa_pkg::NS_PER_SEC);
    end
  end

  // Choose what the second divider works on
  always_ff @(posedge clk) begin
    if (en) begin
      f_q.func   <= e_c.func;
      f_q.ls     <= e_c.ls;
      f_q.ln     <= e_c.ln;
      f_q.rs     <= e_c.rs;
      f_q.rn     <= e_c.rn;
      f_q.scale  <= e_c.scale;
      f_q.gt     <= e_c.gt;
      f_q.eq     <= e_c.eq;
      f_q.prod_b <= e_c.prod_b;
      f_q.a      <= e_a;
      if (e_c.func == snsa_pkg::FN_MUL) begin
        f_dvd <= e_c.prod_a;
        f_dvs <= 32'(snsa_pkg::NS_PER_SEC);
      end else begin
        f_dvd <= e_rprod + 62'(e_c.ln);
        f_dvs <= e_c.scale;
      end
    end
  end

  // Nanosecond quotient, or carry into seconds for multiply
  snsa_div #(
    .QW     (32),
    .DW     (32),
    .SIDE_W ($bits(f_t))
  ) u_div_ns (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (f_v),
    .in_rem     (32'(f_dvd[61:32])),
    .in_bits    (f_dvd[31:0]),
    .in_divisor (f_dvs),
    .in_side    (f_q),
    .out_valid  (d2_v),
    .out_quot   (d2_q),
    .out_rem    (d2_r),
    .out_side   (d2_side)
  );

  snsa_result #(
    .SEC_BITS (SEC_BITS),
    .SW       (SW),
    .PB_W     (PB_W)
  ) u_result (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (d2_v),
    .func       (d2_side.func),
    .ls         (d2_side.ls),
    .ln         (d2_side.ln),
    .rs         (d2_side.rs),
    .rn         (d2_side.rn),
    .scale      (d2_side.scale),
    .gt         (d2_side.gt),
    .eq         (d2_side.eq),
    .prod_b     (d2_side.prod_b),
    .quot_a     (d2_side.a),
    .quot       (d2_q),
    .rem        (d2_r),
    .out_valid  (r_v),
    .res_sec    (r_sec),
    .res_nsec   (r_nsec),
    .res_gt     (r_gt),
    .res_eq     (r_eq),
    .res_status (r_status)
  );

  assign m_tvalid = r_v;
  assign m_tdata  = {6'd0, r_status, r_eq, r_gt, r_nsec, r_sec};

  // Checks
  `SNSA_ASSERT_NOW(a_nsec_range, clk, rst, m_tvalid, r_nsec < snsa_pkg::NS_PER_SEC)
  `SNSA_ASSERT_NOW(a_ovf_sat, clk, rst, m_tvalid && r_status == snsa_pkg::ST_OVF,
                   r_nsec == snsa_pkg::NS_TOP)
  `SNSA_ASSERT_NOW(a_flags_excl, clk, rst, m_tvalid, !(r_gt && r_eq))
  `SNSA_ASSERT_NEXT(a_enter, clk, rst, s_tvalid && s_tready, a_v)

endmodule

`default_nettype wire
